// ===== design/tri_ang_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle angle package
// Shared widths, request and result types, and the arctangent table used by
// the angle lanes.
// ----------------------------------------------------------------------------
package tri_ang_pkg;

	localparam int SIDE_BITS  = 16;
	localparam int ANGLE_BITS = 16;

	localparam int PROD_W   = 2 * SIDE_BITS;
	localparam int DEN_W    = PROD_W + 1;
	localparam int REM_W    = PROD_W + 2;
	localparam int Q_FRAC   = 30;
	localparam int SQ_W     = 62;
	localparam int SQRT_N   = 31;
	localparam int CR_W     = 34;
	localparam int CORDIC_N = 32;

	localparam int LAT_FRONT = 2;
	localparam int LAT_LANE  = 1 + Q_FRAC + 1 + SQRT_N + 1 + CORDIC_N + 1;
	localparam int LAT_TOTAL = LAT_FRONT + LAT_LANE + 1;

	typedef struct packed {
		logic [SIDE_BITS-1:0] side_a;
		logic [SIDE_BITS-1:0] side_b;
		logic [SIDE_BITS-1:0] side_c;
	} req_t;

	typedef struct packed {
		logic [ANGLE_BITS:0] angle_a;
		logic [ANGLE_BITS:0] angle_b;
		logic [ANGLE_BITS:0] angle_c;
		logic                invalid;
	} res_t;

	typedef struct packed {
		logic             neg;
		logic [REM_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} lane_in_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			5'd24:   v = 32'h00000029;
			5'd25:   v = 32'h00000014;
			5'd26:   v = 32'h0000000A;
			5'd27:   v = 32'h00000005;
			5'd28:   v = 32'h00000003;
			5'd29:   v = 32'h00000001;
			5'd30:   v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ===== design/tri_ang_front.sv =====
// ----------------------------------------------------------------------------
// Triangle angle front end
// Forms the side products, the validity check and, for each lane, the
// magnitude and sign of the cosine numerator and its denominator.
// ----------------------------------------------------------------------------
module tri_ang_front import tri_ang_pkg::*; (
	input  logic     clk,
	input  req_t     req,
	output lane_in_t lane [3],
	output logic     bad
);

	logic [PROD_W-1:0] aa_s1, bb_s1, cc_s1, ab_s1, ac_s1, bc_s1;
	logic              bad_s1;
	lane_in_t          lane_s2 [3];
	logic              bad_s2;
	logic [SIDE_BITS:0] sa, sb, sc;
	logic [PROD_W:0]   sum_a, sum_b, sum_c;

	assign sa = {1'b0, req.side_a};
	assign sb = {1'b0, req.side_b};
	assign sc = {1'b0, req.side_c};

	always_ff @(posedge clk) begin
		aa_s1  <= req.side_a * req.side_a;
		bb_s1  <= req.side_b * req.side_b;
		cc_s1  <= req.side_c * req.side_c;
		ab_s1  <= req.side_a * req.side_b;
		ac_s1  <= req.side_a * req.side_c;
		bc_s1  <= req.side_b * req.side_c;
		bad_s1 <= (req.side_a == '0) || (req.side_b == '0) || (req.side_c == '0) ||
			(sa > sb + sc) || (sb > sa + sc) || (sc > sa + sb);
	end

	assign sum_a = {1'b0, bb_s1} + {1'b0, cc_s1};
	assign sum_b = {1'b0, aa_s1} + {1'b0, cc_s1};
	assign sum_c = {1'b0, aa_s1} + {1'b0, bb_s1};

	function automatic lane_in_t make_lane(input logic [PROD_W:0] sum,
			input logic [PROD_W-1:0] pp, input logic [PROD_W-1:0] uv);
		lane_in_t  l;
		logic [PROD_W:0] p;
		p     = {1'b0, pp};
		l.neg = sum < p;
		l.mag = l.neg ? REM_W'(p - sum) : REM_W'(sum - p);
		l.den = {uv, 1'b0};
		return l;
	endfunction

	always_ff @(posedge clk) begin
		lane_s2[0] <= make_lane(sum_a, aa_s1, bc_s1);
		lane_s2[1] <= make_lane(sum_b, bb_s1, ac_s1);
		lane_s2[2] <= make_lane(sum_c, cc_s1, ab_s1);
		bad_s2     <= bad_s1;
	end

	assign lane = lane_s2;
	assign bad  = bad_s2;

endmodule

// ===== design/tri_ang_lane.sv =====
// ----------------------------------------------------------------------------
// Triangle angle lane
// One angle: a restoring divider for the cosine, a digit-by-digit square root
// for the sine and a pipelined CORDIC for the arccosine, one step per stage.
// ----------------------------------------------------------------------------
module tri_ang_lane import tri_ang_pkg::*; (
	input  logic                clk,
	input  lane_in_t            din,
	output logic [ANGLE_BITS:0] angle
);

	logic [REM_W-1:0]  dv_r_s   [Q_FRAC+1];
	logic [DEN_W-1:0]  dv_den_s [Q_FRAC+1];
	logic [Q_FRAC-1:0] dv_q_s   [Q_FRAC+1];
	logic              dv_full_s[Q_FRAC+1];
	logic              dv_neg_s [Q_FRAC+1];

	logic [SQ_W-1:0]   sq_v_s   [SQRT_N+1];
	logic [SQ_W-1:0]   sq_res_s [SQRT_N+1];
	logic [Q_FRAC:0]   sq_q_s   [SQRT_N+1];
	logic              sq_neg_s [SQRT_N+1];

	logic signed [CR_W-1:0] cr_x_s [CORDIC_N+1];
	logic signed [CR_W-1:0] cr_y_s [CORDIC_N+1];
	logic signed [CR_W-1:0] cr_z_s [CORDIC_N+1];

	logic [ANGLE_BITS:0] angle_s;
	logic                full;
	logic [Q_FRAC:0]     qv;
	logic [SQ_W-1:0]     qq;
	logic signed [CR_W-1:0] sv, qs, zc, zr;

	assign full = {1'b0, din.mag} >= {2'b0, din.den};

	always_ff @(posedge clk) begin
		dv_r_s[0]    <= full ? '0 : din.mag;
		dv_den_s[0]  <= din.den;
		dv_q_s[0]    <= '0;
		dv_full_s[0] <= full;
		dv_neg_s[0]  <= din.neg;
	end

	for (genvar k = 0; k < Q_FRAC; k++) begin : g_div
		logic [REM_W-1:0] r2;
		assign r2 = {dv_r_s[k][REM_W-2:0], 1'b0};
		always_ff @(posedge clk) begin
			if (r2 >= {1'b0, dv_den_s[k]}) begin
				dv_r_s[k+1] <= r2 - {1'b0, dv_den_s[k]};
				dv_q_s[k+1] <= {dv_q_s[k][Q_FRAC-2:0], 1'b1};
			end else begin
				dv_r_s[k+1] <= r2;
				dv_q_s[k+1] <= {dv_q_s[k][Q_FRAC-2:0], 1'b0};
			end
			dv_den_s[k+1]  <= dv_den_s[k];
			dv_full_s[k+1] <= dv_full_s[k];
			dv_neg_s[k+1]  <= dv_neg_s[k];
		end
	end

	assign qv = {dv_full_s[Q_FRAC], dv_q_s[Q_FRAC]};
	assign qq = SQ_W'(qv) * SQ_W'(qv);

	always_ff @(posedge clk) begin
		sq_v_s[0]   <= (SQ_W'(1) << (2 * Q_FRAC)) - qq;
		sq_res_s[0] <= '0;
		sq_q_s[0]   <= qv;
		sq_neg_s[0] <= dv_neg_s[Q_FRAC];
	end

	for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
		localparam int SH = 2 * Q_FRAC - 2 * k;
		logic [SQ_W-1:0] bitv, trial;
		assign bitv  = SQ_W'(1) << SH;
		assign trial = sq_res_s[k] + bitv;
		always_ff @(posedge clk) begin
			if (sq_v_s[k] >= trial) begin
				sq_v_s[k+1]   <= sq_v_s[k] - trial;
				sq_res_s[k+1] <= (sq_res_s[k] >> 1) + bitv;
			end else begin
				sq_v_s[k+1]   <= sq_v_s[k];
				sq_res_s[k+1] <= sq_res_s[k] >> 1;
			end
			sq_q_s[k+1]   <= sq_q_s[k];
			sq_neg_s[k+1] <= sq_neg_s[k];
		end
	end

	assign sv = CR_W'(sq_res_s[SQRT_N]);
	assign qs = CR_W'(sq_q_s[SQRT_N]);

	always_ff @(posedge clk) begin
		if (sq_neg_s[SQRT_N]) begin
			cr_x_s[0] <= sv;
			cr_y_s[0] <= qs;
			cr_z_s[0] <= CR_W'(1) <<< 30;
		end else begin
			cr_x_s[0] <= qs;
			cr_y_s[0] <= sv;
			cr_z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		logic signed [CR_W-1:0] at;
		assign at = CR_W'(atan_entry(5'(i)));
		always_ff @(posedge clk) begin
			if (cr_y_s[i] > 0) begin
				cr_x_s[i+1] <= cr_x_s[i] + (cr_y_s[i] >>> i);
				cr_y_s[i+1] <= cr_y_s[i] - (cr_x_s[i] >>> i);
				cr_z_s[i+1] <= cr_z_s[i] + at;
			end else begin
				cr_x_s[i+1] <= cr_x_s[i] - (cr_y_s[i] >>> i);
				cr_y_s[i+1] <= cr_y_s[i] + (cr_x_s[i] >>> i);
				cr_z_s[i+1] <= cr_z_s[i] - at;
			end
		end
	end

	always_comb begin
		if (cr_z_s[CORDIC_N] < 0)
			zc = '0;
		else if (cr_z_s[CORDIC_N] > (CR_W'(1) <<< 31))
			zc = CR_W'(1) <<< 31;
		else
			zc = cr_z_s[CORDIC_N];
		zr = (zc + (CR_W'(1) <<< (30 - ANGLE_BITS))) >>> (31 - ANGLE_BITS);
	end

	always_ff @(posedge clk) begin
		angle_s <= zr[ANGLE_BITS:0];
	end

	assign angle = angle_s;

endmodule

// ===== design/triangle_angles_from_sides_unit.sv =====
// Throughput: one request per cycle; busy is always low.
// The lane pipelines hold 30 divider, 31 square-root and
// 32 CORDIC stages, one step each, plus front, conversion and output stages.
// Reset clears the valid chain, so no result is reported for a request that
// was in flight when reset was asserted.
// ----------------------------------------------------------------------------
// Triangle angles from sides
// Three parallel lanes find the angles by the law of cosines; the output
// stage merges them with the validity check.
// ----------------------------------------------------------------------------
module triangle_angles_from_sides_unit import tri_ang_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t res
);

	lane_in_t            lane_in [3];
	logic                bad_front;
	logic [ANGLE_BITS:0] lane_angle [3];
	logic [LAT_TOTAL-1:0] vld_q;
	logic                bad_q [LAT_LANE];
	res_t                res_q;

	assign busy = 1'b0;

	tri_ang_front u_front (
		.clk  (clk),
		.req  (req),
		.lane (lane_in),
		.bad  (bad_front)
	);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		tri_ang_lane u_lane (
			.clk   (clk),
			.din   (lane_in[l]),
			.angle (lane_angle[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT_TOTAL-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		bad_q[0] <= bad_front;
		for (int n = 1; n < LAT_LANE; n++)
			bad_q[n] <= bad_q[n-1];
	end

	always_ff @(posedge clk) begin
		if (bad_q[LAT_LANE-1]) begin
			res_q.angle_a <= '0;
			res_q.angle_b <= '0;
			res_q.angle_c <= '0;
			res_q.invalid <= 1'b1;
		end else begin
			res_q.angle_a <= lane_angle[0];
			res_q.angle_b <= lane_angle[1];
			res_q.angle_c <= lane_angle[2];
			res_q.invalid <= 1'b0;
		end
	end

	assign done = vld_q[LAT_TOTAL-1];
	assign res  = res_q;

endmodule

// ===== design/tri_ang_chk.sv =====
// ----------------------------------------------------------------------------
// Triangle angle checker
// Port-level checks on the timing and the contents of results.
// ----------------------------------------------------------------------------
module tri_ang_chk import tri_ang_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t res
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("Busy raised.");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT_TOTAL))
		else $error("Result without a request.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.invalid |->
		res.angle_a == '0 && res.angle_b == '0 && res.angle_c == '0)
		else $error("Invalid result carries angles.");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.angle_a <= (1 << ANGLE_BITS) && res.angle_b <= (1 << ANGLE_BITS)
		&& res.angle_c <= (1 << ANGLE_BITS))
		else $error("Angle above pi.");

endmodule

bind triangle_angles_from_sides_unit tri_ang_chk u_chk (.*);

// ===== tb/triangle_angles_from_sides_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle angles from sides testbench
// Drives side triples, some well-formed and some not, through the command
// port with random gaps, predicts the three angles and the invalid flag with
// an independent fixed-point model and checks every result in order.
// ----------------------------------------------------------------------------
module triangle_angles_from_sides_unit_tb;
	import tri_ang_pkg::*;

	localparam int WATCHDOG_LIMIT = 20 * LAT_TOTAL + 1000;
	localparam int RANDOM_REQUESTS = 1450;

	class angle_scoreboard;
		res_t pending_angles[$];
		int   fail_count;
		int   checked_count;
		int   invalid_count;
		int   degenerate_count;

		function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int sh);
			return v >>> sh;
		endfunction

		function automatic logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v = v - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		function automatic logic [ANGLE_BITS:0] opposite_angle(logic [63:0] p, logic [63:0] u,
				logic [63:0] v);
			logic [127:0] sum_sq;
			logic [127:0] opp_sq;
			logic [127:0] den;
			logic [127:0] rem;
			logic         obtuse;
			logic signed [63:0] cosq, sinq, x, y, z, nx, ny;
			logic [63:0]  qq;
			sum_sq = u * u + v * v;
			opp_sq = p * p;
			den = 2 * u * v;
			obtuse = sum_sq < opp_sq;
			rem = obtuse ? opp_sq - sum_sq : sum_sq - opp_sq;
			cosq = 0;
			if (rem >= den) begin
				cosq = 64'sd1 << 30;
			end else begin
				for (int i = 0; i < 30; i++) begin
					rem = rem << 1;
					cosq = cosq << 1;
					if (rem >= den) begin
						rem = rem - den;
						cosq = cosq | 1;
					end
				end
			end
			qq = cosq;
			sinq = int_sqrt((64'd1 << 60) - qq * qq);
			if (obtuse) begin
				x = sinq; y = cosq; z = 64'sd1 << 30;
			end else begin
				x = cosq; y = sinq; z = 0;
			end
			for (int i = 0; i < CORDIC_N; i++) begin
				if (y > 0) begin
					nx = x + floor_shift(y, i);
					ny = y - floor_shift(x, i);
					z = z + $signed({32'd0, atan_entry(i[4:0])});
				end else begin
					nx = x - floor_shift(y, i);
					ny = y + floor_shift(x, i);
					z = z - $signed({32'd0, atan_entry(i[4:0])});
				end
				x = nx;
				y = ny;
			end
			if (z < 0) z = 0;
			if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
			z = (z + (64'sd1 << (30 - ANGLE_BITS))) >>> (31 - ANGLE_BITS);
			return z[ANGLE_BITS:0];
		endfunction

		function void note_request(req_t r);
			logic [63:0] a, b, c;
			res_t e;
			a = r.side_a; b = r.side_b; c = r.side_c;
			e = '0;
			if (a == 0 || b == 0 || c == 0 || a > b + c || b > a + c || c > a + b) begin
				e.invalid = 1'b1;
				invalid_count++;
			end else begin
				if (a == b + c || b == a + c || c == a + b) degenerate_count++;
				e.angle_a = opposite_angle(a, b, c);
				e.angle_b = opposite_angle(b, a, c);
				e.angle_c = opposite_angle(c, a, b);
			end
			pending_angles.push_back(e);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				fail_count++;
				return;
			end
			e = pending_angles.pop_front();
			checked_count++;
			if (got.angle_a !== e.angle_a) begin
				$display("%0t: angle_a expected %0d actual %0d", $time, e.angle_a, got.angle_a);
				fail_count++;
			end
			if (got.angle_b !== e.angle_b) begin
				$display("%0t: angle_b expected %0d actual %0d", $time, e.angle_b, got.angle_b);
				fail_count++;
			end
			if (got.angle_c !== e.angle_c) begin
				$display("%0t: angle_c expected %0d actual %0d", $time, e.angle_c, got.angle_c);
				fail_count++;
			end
			if (got.invalid !== e.invalid) begin
				$display("%0t: invalid expected %0b actual %0b", $time, e.invalid, got.invalid);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	res_t res;

	angle_scoreboard board;
	int   idle_cycles;
	bit   calm_phase;

	triangle_angles_from_sides_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_request(req);
				idle_cycles <= 0;
			end else if (done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (done) board.check_result(res);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding",
					board.pending_angles.size());
				$display("triangle_angles_from_sides_unit_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_request(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		if (!calm_phase && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		start <= 1'b1;
		req <= '{side_a: a, side_b: b, side_c: c};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_request();
		logic [15:0] a, b, c, lim;
		int kind;
		kind = $urandom_range(0, 9);
		lim = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'(($urandom_range(1, 4) == 1) ?
			$urandom_range(1, 15) : $urandom_range(1, 2000));
		a = 16'($urandom_range(1, lim));
		b = 16'($urandom_range(1, lim));
		if (kind <= 5) begin
			// Well-formed triangle: pick c inside the range the other two allow.
			c = 16'($urandom_range((a > b) ? a - b : b - a,
				(32'(a) + b > 65535) ? 65535 : a + b));
			if (c == 0) c = 1;
		end else if (kind == 6) begin
			c = (32'(a) + b > 65535) ? 16'((a > b) ? a - b : b - a) : a + b;
			if (c == 0) c = a + b;
		end else if (kind == 7) begin
			c = 16'($urandom);
		end else if (kind == 8) begin
			c = (32'(a) + b >= 65535) ? 16'd0 : a + b + 16'($urandom_range(1, 50));
		end else begin
			a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
		end
		case ($urandom_range(0, 2))
			0: send_request(a, b, c);
			1: send_request(c, a, b);
			default: send_request(b, c, a);
		endcase
	endtask

	initial begin
		board = new();
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		idle_cycles = 0;
		calm_phase = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(16'd0, 16'd0, 16'd0);
		send_request(16'd0, 16'd5, 16'd5);
		send_request(16'd5, 16'd0, 16'd5);
		send_request(16'd5, 16'd5, 16'd0);
		send_request(16'd1, 16'd1, 16'd1);
		send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(16'd3, 16'd4, 16'd5);
		send_request(16'd5, 16'd3, 16'd4);
		send_request(16'd2, 16'd1, 16'd1);
		send_request(16'd1, 16'd2, 16'd1);
		send_request(16'd1, 16'd1, 16'd2);
		send_request(16'd3, 16'd1, 16'd1);
		send_request(16'd1, 16'd1, 16'd3);
		send_request(16'hFFFF, 16'h7FFF, 16'h8000);
		send_request(16'hFFFF, 16'hFFFF, 16'd1);
		send_request(16'd1, 16'hFFFF, 16'hFFFE);
		send_request(16'hFFFF, 16'd1, 16'd1);
		send_request(16'hAAAA, 16'h5555, 16'hFFFF);
		send_request(16'h5555, 16'hAAAA, 16'h8000);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS - 200) calm_phase = 1'b1;
			send_random_request();
		end
		start <= 1'b0;

		while (board.pending_angles.size() != 0) @(posedge clk);
		repeat (LAT_TOTAL + 10) @(posedge clk);

		$display("Checked %0d results: %0d invalid, %0d degenerate triangles.",
			board.checked_count, board.invalid_count, board.degenerate_count);
		if (board.fail_count == 0)
			$display("triangle_angles_from_sides_unit_tb: PASS");
		else
			$display("triangle_angles_from_sides_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== triangle_angles_from_sides_unit.f =====
design/tri_ang_pkg.sv
design/tri_ang_front.sv
design/tri_ang_lane.sv
design/triangle_angles_from_sides_unit.sv
design/tri_ang_chk.sv
tb/triangle_angles_from_sides_unit_tb.sv
